// ===== design/side_key_short_long_extra_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// side key classifier assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SIDE_KEY_SHORT_LONG_EXTRA_CLASSIFIER_CORE_DEFINES_SVH
`define SIDE_KEY_SHORT_LONG_EXTRA_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SKSLC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("side key classifier check failed");

// next-cycle implication, disabled during reset
`define SKSLC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("side key classifier check failed");

`endif

// ===== design/skslc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skslc_pkg
// types, constants and load-value helpers for the side key classifier
// ----------------------------------------------------------------------------
package skslc_pkg;

	localparam int CNT_W      = 16;
	localparam int UNITS_W    = 8;
	localparam int UNIT_TICKS = 100;
	localparam int WORD_W     = 9;

	localparam logic [UNITS_W-1:0] RESET_LONG_UNITS = 8'd10;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SCAN = 1'b1;

	typedef struct packed {
		logic command;
		logic first_key_level;
		logic second_key_level;
		logic talk_key_level;
		logic keypad_held;
	} item_t;

	typedef struct packed {
		logic first_down;
		logic first_short;
		logic first_long;
		logic first_extra_long;
		logic second_down;
		logic second_short;
		logic second_long;
		logic second_extra_long;
		logic talk_down;
		logic changed;
	} result_t;

	// per-key control from the sequencing logic
	typedef struct packed {
		logic tick;
		logic scan;
		logic reload;
		logic classify;
	} key_ctl_t;

	// per-key classification, down in bit 0
	typedef struct packed {
		logic xlong_hold;
		logic long_hold;
		logic short_rel;
		logic down;
	} key_bits_t;

	// units * 100, at most 25500
	function automatic logic [CNT_W-1:0] long_load(input logic [UNITS_W-1:0] units);
		long_load = CNT_W'(CNT_W'(units) * CNT_W'(UNIT_TICKS));
	endfunction

	// ((units * 3) >> 1) * 100, at most 38200
	function automatic logic [CNT_W-1:0] extra_load(input logic [UNITS_W-1:0] units);
		logic [UNITS_W+1:0] triple;
		triple     = (UNITS_W+2)'(units) * (UNITS_W+2)'(3);
		extra_load = CNT_W'(CNT_W'(triple[UNITS_W+1:1]) * CNT_W'(UNIT_TICKS));
	endfunction

endpackage

// ===== design/skslc_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skslc_key_unit
// one side key: pressed/long/extra flags, countdown and classification
// ----------------------------------------------------------------------------
module skslc_key_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skslc_pkg::key_ctl_t           ctl,
	input  logic                          level,
	input  logic [skslc_pkg::CNT_W-1:0]   long_ld,
	input  logic [skslc_pkg::CNT_W-1:0]   extra_ld,
	output skslc_pkg::key_bits_t          bits
);
	import skslc_pkg::*;

	logic             pressed_q, long_q, extra_q;
	logic [CNT_W-1:0] cnt_q;

	logic             p1, l1, e1;
	logic [CNT_W-1:0] t1;
	logic             pc, lc, ec;
	logic [CNT_W-1:0] tc;
	logic             zero1;

	// new press loads the long time before anything else
	always_comb begin
		p1 = pressed_q;
		l1 = long_q;
		e1 = extra_q;
		t1 = cnt_q;
		if (level && !pressed_q) begin
			p1 = 1'b1;
			l1 = 1'b0;
			e1 = 1'b0;
			t1 = long_ld;
		end
	end

	assign zero1 = (t1 == '0);

	// short / long / extra-long classification
	always_comb begin
		pc = p1;
		lc = l1;
		ec = e1;
		tc = t1;
		bits = '0;
		bits.down = level;
		if (level && p1 && l1 && !e1) begin
			if (zero1) begin
				ec = 1'b1;
				bits.xlong_hold = 1'b1;
			end else begin
				bits.long_hold = 1'b1;
			end
		end else if (level && p1 && l1 && e1) begin
			bits.xlong_hold = 1'b1;
		end else if (level && p1 && !l1) begin
			if (zero1) begin
				lc = 1'b1;
				tc = extra_ld;
				bits.long_hold = 1'b1;
			end
		end else if (!level && p1 && !l1 && !zero1) begin
			pc = 1'b0;
			lc = 1'b0;
			ec = 1'b0;
			tc = '0;
			bits.short_rel = 1'b1;
		end else if (!level && p1 && l1) begin
			pc = 1'b0;
			lc = 1'b0;
			ec = 1'b0;
		end
	end

	// state update per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			long_q    <= 1'b0;
			extra_q   <= 1'b0;
			cnt_q     <= '0;
		end else if (ctl.tick) begin
			if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
		end else if (ctl.scan) begin
			if (ctl.reload) begin
				pressed_q <= level;
				long_q    <= 1'b0;
				extra_q   <= 1'b0;
				cnt_q     <= level ? long_ld : '0;
			end else if (ctl.classify) begin
				pressed_q <= pc;
				long_q    <= lc;
				extra_q   <= ec;
				cnt_q     <= tc;
			end else begin
				pressed_q <= p1;
				long_q    <= l1;
				extra_q   <= e1;
				cnt_q     <= t1;
			end
		end
	end

endmodule

// ===== design/side_key_short_long_extra_classifier_core.sv =====
`timescale 1ns / 1ps
// path: a scan transaction passes the input register, then the result register
// throughput: one transaction per cycle unless a scan stalls; ticks give no result
// and never wait on the output; a scan waits in the input register only while the result
// register is full and stalled. reset: flags, countdowns, modifier wait and previous word clear; long time reloads 10
// ----------------------------------------------------------------------------
// side_key_short_long_extra_classifier_core
// side key short/long/extra-long press classifier with push-to-talk level
// ----------------------------------------------------------------------------
module side_key_short_long_extra_classifier_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  skslc_pkg::item_t                item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output skslc_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [skslc_pkg::UNITS_W-1:0]   cfg_data
);
	import skslc_pkg::*;

	item_t             item_s1;
	logic              valid_s1;
	result_t           result_s2;
	logic              valid_s2;
	logic [CNT_W-1:0]  long_ld_q, extra_ld_q;
	logic              mwait_q;
	logic [WORD_W-1:0] prev_q;

	logic              out_free, adv, is_scan;
	logic [WORD_W-1:0] raw_word, cls_word, out_word;
	logic              mod_path, hold_mod, wait_path, wait_change, do_classify, changed;
	key_ctl_t          ctl;
	key_bits_t         bits1, bits2;

	// handshake
	assign out_free     = !valid_s2 || !result_stall;
	assign is_scan      = (item_s1.command == CMD_SCAN);
	assign adv          = valid_s1 && (!is_scan || out_free);
	assign item_stall   = valid_s1 && !adv;
	assign result_valid = valid_s2;
	assign result       = result_s2;
	assign cfg_ready    = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
	end

	// configuration: load values precomputed at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ld_q  <= long_load(RESET_LONG_UNITS);
			extra_ld_q <= extra_load(RESET_LONG_UNITS);
		end else if (cfg_valid && cfg_ready) begin
			long_ld_q  <= long_load(cfg_data);
			extra_ld_q <= extra_load(cfg_data);
		end
	end

	// modifier sequencing
	assign raw_word = {item_s1.talk_key_level, 3'b000, item_s1.second_key_level, 3'b000,
		item_s1.first_key_level};
	assign mod_path    = (raw_word != '0) || mwait_q;
	assign hold_mod    = mod_path && item_s1.keypad_held;
	assign wait_path   = mod_path && !item_s1.keypad_held && mwait_q;
	assign wait_change = wait_path && (raw_word != prev_q);
	assign do_classify = !hold_mod && !wait_path;

	assign ctl.tick     = adv && !is_scan;
	assign ctl.scan     = adv && is_scan;
	assign ctl.reload   = hold_mod || wait_change;
	assign ctl.classify = do_classify;

	skslc_key_unit u_key1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.level    (item_s1.first_key_level),
		.long_ld  (long_ld_q),
		.extra_ld (extra_ld_q),
		.bits     (bits1)
	);

	skslc_key_unit u_key2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.level    (item_s1.second_key_level),
		.long_ld  (long_ld_q),
		.extra_ld (extra_ld_q),
		.bits     (bits2)
	);

	// result word and change flag
	assign cls_word = {item_s1.talk_key_level, bits2, bits1};
	assign out_word = do_classify ? cls_word : raw_word;
	assign changed  = do_classify ? (cls_word != prev_q) : wait_change;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mwait_q <= 1'b0;
			prev_q  <= '0;
		end else if (ctl.scan) begin
			if (hold_mod) mwait_q <= 1'b1;
			else if (wait_change) mwait_q <= 1'b0;
			if (hold_mod || wait_change || do_classify) prev_q <= out_word;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.scan) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			result_s2.first_down        <= out_word[0];
			result_s2.first_short       <= out_word[1];
			result_s2.first_long        <= out_word[2];
			result_s2.first_extra_long  <= out_word[3];
			result_s2.second_down       <= out_word[4];
			result_s2.second_short      <= out_word[5];
			result_s2.second_long       <= out_word[6];
			result_s2.second_extra_long <= out_word[7];
			result_s2.talk_down         <= out_word[8];
			result_s2.changed           <= changed;
		end
	end

endmodule

// ===== design/skslc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skslc_checker
// port-level checks for the side key classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "side_key_short_long_extra_classifier_core_defines.svh"

module skslc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input skslc_pkg::item_t                item,
	input logic                            result_valid,
	input logic                            result_stall,
	input skslc_pkg::result_t              result
);
	import skslc_pkg::*;

	logic one_class_ok, short_up_ok, long_down_ok;

	// press class bits seen on the result port
	assign one_class_ok = ($countones({result.first_short, result.first_long,
		result.first_extra_long}) <= 1) && ($countones({result.second_short,
		result.second_long, result.second_extra_long}) <= 1);
	assign short_up_ok  = !(result.first_short && result.first_down) &&
		!(result.second_short && result.second_down);
	assign long_down_ok = ((!result.first_long && !result.first_extra_long) ||
		result.first_down) && ((!result.second_long && !result.second_extra_long) ||
		result.second_down);

	// a stalled input transaction holds
	`SKSLC_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid && $stable(item))

	// a stalled result transaction holds
	`SKSLC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// at most one press class per key
	`SKSLC_ASSERT_NOW(a_one_class, result_valid, one_class_ok)

	// a short release is only reported with the key up
	`SKSLC_ASSERT_NOW(a_short_up, result_valid, short_up_ok)

	// long and extra-long are only reported while the key is held
	`SKSLC_ASSERT_NOW(a_long_down, result_valid, long_down_ok)

endmodule

bind side_key_short_long_extra_classifier_core skslc_checker u_skslc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the side key classifier against a cycle-free predictor of its key
// state. Directed tests cover short, long and extra-long holds, the keypad
// modifier mode, an expired countdown missed by the scans and the long-time
// register at its extremes. Random key sequences run under several long-time
// settings with random valid gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import skslc_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [UNITS_W-1:0]   cfg_data = '0;

	side_key_short_long_extra_classifier_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// predicted key state and long-time setting
	logic [UNITS_W-1:0]   model_units = RESET_LONG_UNITS;
	logic [1:0]           pressed_f = '0;
	logic [1:0]           long_f = '0;
	logic [1:0]           extra_f = '0;
	logic [CNT_W-1:0]     countdown [2] = '{default: '0};
	logic                 mod_wait = 1'b0;
	logic [WORD_W-1:0]    last_word = '0;

	result_t              reports_due [$];

	int mismatches = 0;
	int scans_sent = 0;
	int ticks_sent = 0;
	int n_short = 0;
	int n_long = 0;
	int n_extra = 0;
	int n_changed = 0;
	int n_settings = 0;

	bit quiet_mode = 1'b0;
	int hold_request = 0;
	int hold_left = 0;

	function automatic logic [CNT_W-1:0] long_ticks();
		return CNT_W'(int'(model_units) * UNIT_TICKS);
	endfunction

	function automatic logic [CNT_W-1:0] extra_ticks();
		return CNT_W'(((int'(model_units) * 3) >> 1) * UNIT_TICKS);
	endfunction

	function automatic void reload_key(int k, bit down);
		pressed_f[k] = down;
		countdown[k] = down ? long_ticks() : '0;
		long_f[k] = 1'b0;
		extra_f[k] = 1'b0;
	endfunction

	function automatic void release_key(int k);
		pressed_f[k] = 1'b0;
		long_f[k] = 1'b0;
		extra_f[k] = 1'b0;
	endfunction

	// one key's hold classification; bits at base: down, short, long, extra-long
	function automatic logic [WORD_W-1:0] classify_key(int k, logic [WORD_W-1:0] w, int base);
		logic d;
		logic p;
		logic l;
		logic e;
		logic t_zero;
		d = w[base];
		p = pressed_f[k];
		l = long_f[k];
		e = extra_f[k];
		t_zero = (countdown[k] == '0);
		if (d && p && l && !e) begin
			w[base+2] = 1'b1;
			if (t_zero) begin
				extra_f[k] = 1'b1;
				w[base+2] = 1'b0;
				w[base+3] = 1'b1;
			end
		end else if (d && p && l && e) begin
			w[base+2] = 1'b0;
			w[base+3] = 1'b1;
		end else if (d && p && !l) begin
			if (t_zero) begin
				long_f[k] = 1'b1;
				w[base+2] = 1'b1;
				countdown[k] = extra_ticks();
			end
		end else if (!d && p && !l && !t_zero) begin
			release_key(k);
			countdown[k] = '0;
			w[base+1] = 1'b1;
			w[base+2] = 1'b0;
			w[base+3] = 1'b0;
		end else if (!d && p && l) begin
			release_key(k);
			w[base+2] = 1'b0;
			w[base+3] = 1'b0;
		end
		return w;
	endfunction

	function automatic void post_report(logic [WORD_W-1:0] w, logic chg);
		result_t r;
		r.first_down        = w[0];
		r.first_short       = w[1];
		r.first_long        = w[2];
		r.first_extra_long  = w[3];
		r.second_down       = w[4];
		r.second_short      = w[5];
		r.second_long       = w[6];
		r.second_extra_long = w[7];
		r.talk_down         = w[8];
		r.changed           = chg;
		reports_due.push_back(r);
		n_short   += w[1] + w[5];
		n_long    += w[2] + w[6];
		n_extra   += w[3] + w[7];
		n_changed += chg;
	endfunction

	// apply one accepted transaction to the predicted state
	function automatic void advance_keys(item_t it);
		logic [WORD_W-1:0] w;
		logic chg;
		if (it.command == CMD_TICK) begin
			for (int k = 0; k < 2; k++)
				if (countdown[k] != '0)
					countdown[k] = countdown[k] - 1'b1;
			return;
		end
		w = '0;
		if (it.first_key_level) begin
			w[0] = 1'b1;
			if (!pressed_f[0])
				reload_key(0, 1'b1);
		end
		if (it.second_key_level) begin
			w[4] = 1'b1;
			if (!pressed_f[1])
				reload_key(1, 1'b1);
		end
		if (it.talk_key_level)
			w[8] = 1'b1;
		if (w != '0 || mod_wait) begin
			// side keys used as keypad modifiers
			if (it.keypad_held) begin
				mod_wait = 1'b1;
				reload_key(0, it.first_key_level);
				reload_key(1, it.second_key_level);
				last_word = w;
				post_report(w, 1'b0);
				return;
			end
			if (mod_wait) begin
				if (w != last_word) begin
					mod_wait = 1'b0;
					reload_key(0, it.first_key_level);
					reload_key(1, it.second_key_level);
					last_word = w;
					post_report(w, 1'b1);
				end else begin
					post_report(w, 1'b0);
				end
				return;
			end
		end
		w = classify_key(0, w, 0);
		w = classify_key(1, w, 4);
		chg = (w != last_word);
		if (chg)
			last_word = w;
		post_report(w, chg);
	endfunction

	function automatic void check_bit(string field, logic want, logic got);
		if (want !== got) begin
			$error("%s: expected %0b, got %0b", field, want, got);
			mismatches++;
		end
	endfunction

	// result check, register writes and prediction at each edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (reports_due.size() == 0) begin
					$error("result transaction with no scan waiting: %b", result);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					check_bit("first_down", want.first_down, result.first_down);
					check_bit("first_short", want.first_short, result.first_short);
					check_bit("first_long", want.first_long, result.first_long);
					check_bit("first_extra_long", want.first_extra_long,
						result.first_extra_long);
					check_bit("second_down", want.second_down, result.second_down);
					check_bit("second_short", want.second_short, result.second_short);
					check_bit("second_long", want.second_long, result.second_long);
					check_bit("second_extra_long", want.second_extra_long,
						result.second_extra_long);
					check_bit("talk_down", want.talk_down, result.talk_down);
					check_bit("changed", want.changed, result.changed);
				end
			end
			if (cfg_valid && cfg_ready)
				model_units = cfg_data;
			if (item_valid && !item_stall)
				advance_keys(item);
		end
	end

	// result side: random stalls, counted hold-offs, quiet stretches
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (quiet_mode) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 26);
		end
	end

	// offer one transaction, with a random gap ahead of it
	task automatic send_item(item_t x);
		if (!quiet_mode && $urandom_range(99) < 26) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item <= x;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (x.command == CMD_SCAN)
			scans_sent++;
		else
			ticks_sent++;
	endtask

	task automatic scan(bit k1, bit k2, bit talk, bit keypad);
		item_t x;
		x.command = CMD_SCAN;
		x.first_key_level = k1;
		x.second_key_level = k2;
		x.talk_key_level = talk;
		x.keypad_held = keypad;
		send_item(x);
	endtask

	// tick transactions; the level bits are don't-care and random
	task automatic ticks(int n);
		item_t x;
		repeat (n) begin
			x = item_t'(5'($urandom));
			x.command = CMD_TICK;
			send_item(x);
		end
	endtask

	// stop offering and wait until every predicted report is back
	task automatic wait_for_reports();
		item_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_long_units(logic [UNITS_W-1:0] v);
		wait_for_reports();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// short releases at the reset long time, countdown saturation
	task automatic test_short_press();
		scan(0, 0, 0, 0);
		scan(1, 0, 1, 0);
		ticks(3);
		scan(0, 0, 1, 0);
		scan(0, 1, 0, 0);
		scan(0, 0, 0, 0);
		ticks(2);
	endtask

	// keypad held: modifier capture, wait for a new pattern
	task automatic test_modifier_keys();
		scan(0, 0, 0, 1);
		scan(1, 0, 0, 1);
		scan(1, 0, 0, 1);
		scan(1, 0, 0, 0);
		scan(1, 1, 0, 0);
		scan(0, 0, 1, 1);
		scan(0, 0, 0, 0);
		scan(0, 0, 0, 0);
	endtask

	// zero long time: long on the press scan, extra-long on the next
	task automatic test_zero_long_time();
		set_long_units('0);
		scan(1, 1, 0, 0);
		scan(1, 1, 0, 0);
		scan(1, 1, 1, 0);
		scan(0, 1, 0, 0);
		scan(0, 0, 0, 0);
	endtask

	// release after expiry without a scan, then exact thresholds
	task automatic test_expiry_before_scan();
		set_long_units(8'd1);
		scan(1, 0, 0, 0);
		ticks(100);
		scan(0, 0, 0, 0);
		scan(1, 0, 0, 0);
		ticks(100);
		scan(1, 0, 0, 0);
		scan(0, 0, 0, 0);
		scan(0, 1, 0, 0);
		ticks(99);
		scan(0, 1, 0, 0);
		ticks(1);
		scan(0, 1, 0, 0);
		scan(0, 0, 0, 0);
	endtask

	// largest long time: holds well short of it release as short presses
	task automatic test_register_extremes();
		set_long_units(8'd255);
		scan(1, 0, 0, 0);
		ticks(20);
		scan(1, 1, 0, 0);
		ticks(5);
		scan(0, 1, 0, 0);
		scan(0, 0, 0, 0);
	endtask

	// tick count for one hold segment, near a threshold when short enough
	function automatic int pick_hold(int seg);
		int target;
		if (model_units > 1 || $urandom_range(3) == 0)
			return $urandom_range(0, 20);
		target = (seg == 0) ? int'(long_ticks()) : int'(extra_ticks());
		target = target + $urandom_range(0, 4) - 2;
		return (target < 0) ? 0 : target;
	endfunction

	task automatic run_key_sequence();
		bit [1:0] held;
		bit [1:0] left;
		int segs;
		held = 2'($urandom_range(1, 3));
		segs = $urandom_range(1, 3);
		scan(held[0], held[1], 1'($urandom), 0);
		for (int s = 0; s < segs; s++) begin
			ticks(pick_hold(s));
			scan(held[0], held[1], 1'($urandom), $urandom_range(9) == 0);
		end
		left = held & 2'($urandom);
		scan(left[0], left[1], 1'($urandom), 0);
		if (left != '0)
			scan(0, 0, 1'($urandom), 0);
	endtask

	task automatic run_modifier_sequence();
		bit [2:0] lv;
		repeat ($urandom_range(1, 3)) begin
			lv = 3'($urandom);
			scan(lv[0], lv[1], lv[2], 1);
		end
		repeat ($urandom_range(0, 3))
			scan(lv[0], lv[1], lv[2], 0);
		if ($urandom_range(3) != 0)
			ticks($urandom_range(0, 5));
		lv = 3'($urandom);
		scan(lv[0], lv[1], lv[2], $urandom_range(3) == 0);
	endtask

	// random sequences under several long-time settings
	task automatic test_random_sequences();
		logic [UNITS_W-1:0] settings [6];
		int phase_start;
		int pick;
		settings = '{8'd0, 8'd1, 8'd2, 8'd3, UNITS_W'($urandom_range(1, 255)), 8'd255};
		for (int ph = 0; ph < 6; ph++) begin
			set_long_units(settings[ph]);
			quiet_mode = (ph == 3);
			phase_start = scans_sent + ticks_sent;
			while (scans_sent + ticks_sent - phase_start < 260) begin
				pick = $urandom_range(99);
				if (pick < 60)
					run_key_sequence();
				else if (pick < 80)
					run_modifier_sequence();
				else
					repeat ($urandom_range(1, 5))
						send_item(item_t'(5'($urandom)));
			end
			quiet_mode = 1'b0;
		end
	endtask

	// long output hold-off with scans still offered, then a full drain
	task automatic test_output_backpressure();
		set_long_units(8'd1);
		hold_request = 300;
		repeat (40)
			scan(1'($urandom), 1'($urandom), 1'($urandom), 0);
		wait_for_reports();
		repeat (10)
			scan(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_press();
		test_modifier_keys();
		test_zero_long_time();
		test_expiry_before_scan();
		test_register_extremes();
		test_output_backpressure();
		test_random_sequences();
		wait_for_reports();
		repeat (8) @(posedge clk);
		$display("covered %0d scans and %0d ticks over %0d long-time settings",
			scans_sent, ticks_sent, n_settings);
		$display("reports seen: %0d short, %0d long, %0d extra-long, %0d changed",
			n_short, n_long, n_extra, n_changed);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/skslc_pkg.sv
design/skslc_key_unit.sv
design/side_key_short_long_extra_classifier_core.sv
design/skslc_checker.sv
bench/tb_top.sv
